/* sv/sunday_substring_search_macros.svh */
// Assertion macros shared by the search block.
`ifndef SUNDAY_SUBSTRING_SEARCH_MACROS_SVH
`define SUNDAY_SUBSTRING_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sss_pkg.sv */
`timescale 1ns / 1ps

package sss_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int MAX_TEXT_DEF    = 4096;
    localparam int POS_W           = 12;
    localparam int BYTE_W          = 8;
    localparam int TABLE_DEPTH     = 256;

    // Beat kinds on the input channel.
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic              overflow;
    } t_result;

endpackage

/* sv/sss_in_if.sv */
`timescale 1ns / 1ps

interface sss_in_if import sss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output command, output data_byte, output last, input ready);
    modport sink   (input valid, input command, input data_byte, input last, output ready);
endinterface

/* sv/sss_out_if.sv */
`timescale 1ns / 1ps

interface sss_out_if import sss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;

    modport source (output valid, output found, output position, output overflow, input ready);
    modport sink   (input valid, input found, input position, input overflow, output ready);
endinterface

/* sv/sss_out_reg.sv */
`timescale 1ns / 1ps

// Single-entry output register for the result beat.
module sss_out_reg import sss_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_result   i_result,
    sss_out_if.source o_res
);

    logic    r_full;
    t_result r_data;

    assign o_ready = !r_full || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_full <= 1'b1;
        end else if (o_res.ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_result;
        end
    end

    assign o_res.valid    = r_full;
    assign o_res.found    = r_data.found;
    assign o_res.position = r_data.position;
    assign o_res.overflow = r_data.overflow;

endmodule

/* sv/sunday_substring_search.sv */
`timescale 1ns / 1ps

// Sunday substring search. Send the pattern as beats with command low, the
// final one marked by last, then the text as beats with command high; the
// text beat marked last starts the search, and one result beat follows with
// the found flag, the offset of the first match (zero when nothing matches)
// and the overflow flag, which reports bytes dropped beyond MAX_PATTERN or
// MAX_TEXT since the current pattern began. Pattern and text beats are taken
// at one beat per cycle. From the last text beat until the result is handed
// to the output register, the input is stalled: the search starts, then for
// every window it tries it sets up the window, compares the bytes one pair at
// a time, and on a mismatch fetches the byte after the window and looks up its
// shift, unless the window already reaches the end of the text; it ends when
// a set-up finds the window past the end of the text or the pattern matches,
// and the result is handed off, after any wait for the output register.
// An empty pattern skips the windows. The pace is set by the single read
// port of the text memory, which serves one byte per cycle. A new pattern
// clears the last-position table at once through a row of valid bits, so
// there is no clearing pass. A result that is not yet taken sits in the
// output register, and the next pattern or text beat is accepted meanwhile.
// A pattern beat after a finished pattern starts a new pattern; a text beat
// while a pattern is still loading closes that pattern as it stands.
module sunday_substring_search import sss_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sss_in_if.sink    i_in,
    sss_out_if.source o_res
);

`include "sunday_substring_search_macros.svh"

    // Pattern length counter, table entry, text length and text address widths.
    localparam int PW  = $clog2(MAX_PATTERN + 1);
    localparam int PW1 = PW + 1;
    localparam int LPW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int TW  = $clog2(MAX_TEXT + 1);
    localparam int TAW = $clog2(MAX_TEXT);
    // Window positions can run past the text by up to two pattern lengths.
    localparam int SW  = $clog2(MAX_TEXT + 2 * MAX_PATTERN + 2);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_CHECK,
        S_CMP,
        S_NEXT,
        S_SHIFT,
        S_RESULT
    } t_state;

    // Control state.
    t_state                 r_state;
    logic                   r_done;
    logic                   r_ovf;
    logic [PW-1:0]          r_plen;
    logic [TW-1:0]          r_tlen;
    logic [TABLE_DEPTH-1:0] r_tvalid;
    logic [TABLE_DEPTH-1:0] n_tvalid;

    // Memories and their registered read data.
    logic [BYTE_W-1:0] pat_mem  [MAX_PATTERN];
    logic [BYTE_W-1:0] text_mem [MAX_TEXT];
    logic [LPW-1:0]    tbl_mem  [TABLE_DEPTH];
    logic [BYTE_W-1:0] r_pat_q;
    logic [BYTE_W-1:0] r_txt_q;
    logic [LPW-1:0]    r_tbl_q;
    logic              r_tv_q;

    // Search working registers.
    logic [SW-1:0]  r_pos;
    logic [SW-1:0]  r_wend;
    logic [TAW-1:0] r_tptr;
    logic [PW-1:0]  r_k;
    logic           r_found;

    logic           w_in_acc;
    logic           w_pat_acc;
    logic           w_txt_acc;
    logic           w_pat_store;
    logic           w_txt_store;
    logic [PW-1:0]  w_plen_eff;
    logic [SW-1:0]  w_n_ext;
    logic [SW-1:0]  w_end;
    logic           w_match;
    logic [PW-1:0]  w_k_next;
    logic [PW1-1:0] w_shift;
    logic [TAW-1:0] w_taddr;
    logic [LPW-1:0] w_paddr;
    logic           w_res_ready;
    t_result        w_result;

    assign i_in.ready = (r_state == S_LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_pat_acc  = w_in_acc && (i_in.command == CMD_PATTERN);
    assign w_txt_acc  = w_in_acc && (i_in.command == CMD_TEXT);

    // A pattern beat after a finished pattern begins a fresh one at index zero.
    assign w_plen_eff  = r_done ? '0 : r_plen;
    assign w_pat_store = w_pat_acc && (w_plen_eff < PW'(MAX_PATTERN));
    assign w_txt_store = w_txt_acc && (r_tlen < TW'(MAX_TEXT));

    assign w_n_ext  = SW'(r_tlen);
    assign w_end    = r_pos + SW'(r_plen);
    assign w_match  = (r_txt_q == r_pat_q);
    assign w_k_next = r_k + PW'(1);

    // Sunday shift: pattern length minus the last position of the byte after
    // the window, or one more than the pattern length when that byte is absent.
    assign w_shift = r_tv_q ? (PW1'(r_plen) - PW1'(r_tbl_q)) : (PW1'(r_plen) + PW1'(1));

    // Read addresses: the window start while setting up, the next byte pair
    // while the window keeps matching, otherwise the byte after the window.
    always_comb begin
        w_taddr = r_pos[TAW-1:0];
        w_paddr = '0;
        case (r_state)
            S_CHECK: begin
                w_taddr = r_pos[TAW-1:0];
                w_paddr = '0;
            end
            S_CMP: begin
                w_paddr = w_k_next[LPW-1:0];
                if (w_match && (w_k_next < r_plen)) begin
                    w_taddr = r_tptr + TAW'(1);
                end else begin
                    w_taddr = r_wend[TAW-1:0];
                end
            end
            default: begin
                w_taddr = r_pos[TAW-1:0];
                w_paddr = '0;
            end
        endcase
    end

    // Pattern memory and the last-position table are written together.
    always_ff @(posedge i_clk) begin
        if (w_pat_store) begin
            pat_mem[w_plen_eff[LPW-1:0]] <= i_in.data_byte;
        end
        r_pat_q <= pat_mem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pat_store) begin
            tbl_mem[i_in.data_byte] <= w_plen_eff[LPW-1:0];
        end
        r_tbl_q <= tbl_mem[r_txt_q];
        r_tv_q  <= r_tvalid[r_txt_q];
    end

    always_ff @(posedge i_clk) begin
        if (w_txt_store) begin
            text_mem[r_tlen[TAW-1:0]] <= i_in.data_byte;
        end
        r_txt_q <= text_mem[w_taddr];
    end

    // Table valid bits: cleared all at once when a new pattern starts.
    always_comb begin
        n_tvalid = r_tvalid;
        if (w_pat_acc && r_done) begin
            n_tvalid = '0;
        end
        if (w_pat_store) begin
            n_tvalid[i_in.data_byte] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else begin
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_done  <= 1'b1;
            r_ovf   <= 1'b0;
            r_plen  <= '0;
            r_tlen  <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_pat_acc) begin
                        if (r_done) begin
                            r_tlen <= '0;
                        end
                        if (w_pat_store) begin
                            r_plen <= w_plen_eff + PW'(1);
                            if (r_done) begin
                                r_ovf <= 1'b0;
                            end
                        end else begin
                            r_plen <= w_plen_eff;
                            r_ovf  <= 1'b1;
                        end
                        r_done <= i_in.last;
                    end
                    if (w_txt_acc) begin
                        r_done <= 1'b1;
                        if (w_txt_store) begin
                            r_tlen <= r_tlen + TW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_pos <= '0;
                    if (r_plen == '0) begin
                        // An empty pattern matches at offset zero.
                        r_found <= 1'b1;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_end > w_n_ext) begin
                        r_found <= 1'b0;
                        r_state <= S_RESULT;
                    end else begin
                        r_wend  <= w_end;
                        r_tptr  <= r_pos[TAW-1:0];
                        r_k     <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_match) begin
                        if (w_k_next == r_plen) begin
                            r_found <= 1'b1;
                            r_state <= S_RESULT;
                        end else begin
                            r_k    <= w_k_next;
                            r_tptr <= r_tptr + TAW'(1);
                        end
                    end else if (r_wend >= w_n_ext) begin
                        // The window already reaches the end of the text.
                        r_found <= 1'b0;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_pos   <= r_pos + SW'(w_shift);
                    r_state <= S_CHECK;
                end
                S_RESULT: begin
                    if (w_res_ready) begin
                        r_tlen  <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign w_result.found    = r_found;
    assign w_result.position = r_found ? POS_W'(r_pos) : '0;
    assign w_result.overflow = r_ovf;

    sss_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_state == S_RESULT),
        .o_ready  (w_res_ready),
        .i_result (w_result),
        .o_res    (o_res)
    );

    // The last text beat always launches a search.
    `SSS_ASSERT_NEXT(a_search_starts, i_clk, i_rst_n, w_txt_acc && i_in.last, r_state == S_START)
    // Compares stay inside the pattern and inside the stored text.
    `SSS_ASSERT_IMPL(a_cmp_bounds, i_clk, i_rst_n, r_state == S_CMP, (r_k < r_plen) && (r_wend <= w_n_ext))
    // A stored pattern byte is marked present in the table.
    `SSS_ASSERT_NEXT(a_table_mark, i_clk, i_rst_n, w_pat_store, r_tvalid[$past(i_in.data_byte)])
    // Fill counts never pass the store depths.
    `SSS_ASSERT_IMPL(a_len_bounds, i_clk, i_rst_n, 1'b1, (r_plen <= PW'(MAX_PATTERN)) && (r_tlen <= TW'(MAX_TEXT)))

endmodule
